>>> src/lmm_pkg.sv
package lmm_pkg;

    localparam int POS_W          = 11;
    localparam int OPERAND_W      = 32;
    localparam int LEAVES_DEF     = 1024;
    localparam int VALUE_BITS_DEF = 32;
    // Length register caps every span, whatever LEAVES is.
    localparam int LEN_MAX        = 2047;

    localparam logic [POS_W-1:0] LEN_RESET = POS_W'(1024);

    localparam logic ST_OK  = 1'b0;
    localparam logic ST_BAD = 1'b1;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_BUILD = 2'd1,
        OP_ADD   = 2'd2,
        OP_FIND  = 2'd3
    } op_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             status;
    } res_t;

endpackage

>>> src/lmm_node_mem.sv
module lmm_node_mem import lmm_pkg::*; #(
    parameter int DEPTH  = 4 * LEAVES_DEF,
    parameter int DATA_W = 3 * VALUE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    output logic                     clearing
);

    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [AW-1:0]     clr_reg;
    logic              clearing_reg;

    // Sweep every entry to zero after reset so pending adds start clear.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            clr_reg <= clr_reg + 1'b1;
            if (clr_reg == LAST)
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    assign clearing = clearing_reg;

endmodule

>>> src/lmm_walker.sv
module lmm_walker import lmm_pkg::*; #(
    parameter int LEAVES     = LEAVES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  op_t                   op,
    input  logic [POS_W-1:0]      lo,
    input  logic [POS_W-1:0]      hi,
    input  logic [VALUE_BITS-1:0] value,
    input  logic [POS_W-1:0]      span,
    output logic                  idle,
    output logic                  res_valid,
    input  logic                  res_ready,
    output res_t                  res,
    output logic                  mem_rd_en,
    output logic [$clog2(4 * ((LEAVES < LEN_MAX) ? LEAVES : LEN_MAX))-1:0] mem_rd_addr,
    input  logic [3*VALUE_BITS-1:0] mem_rd_data,
    output logic                  mem_wr_en,
    output logic [$clog2(4 * ((LEAVES < LEN_MAX) ? LEAVES : LEN_MAX))-1:0] mem_wr_addr,
    output logic [3*VALUE_BITS-1:0] mem_wr_data
);

    localparam int VB          = VALUE_BITS;
    localparam int SPAN_MAX    = (LEAVES < LEN_MAX) ? LEAVES : LEN_MAX;
    localparam int NODE_W      = $clog2(4 * SPAN_MAX);
    localparam int STACK_DEPTH = $clog2(SPAN_MAX) + 1;
    localparam int STK_AW      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 3 * VB;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_VISIT, S_CHK, S_PUSH_A, S_PUSH_B, S_PUSH_N,
        S_COVER, S_PULL_A, S_PULL_B, S_DONE
    } state_t;

    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [POS_W-1:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [VB-1:0]     val_reg, val_next;
    logic [NODE_W-1:0] idx_reg, idx_next;
    logic [POS_W-1:0]  l_reg, l_next, r_reg, r_next;
    logic [1:0]        ph_reg, ph_next;
    logic [SP_W-1:0]   sp_reg, sp_next;
    logic [VB-1:0]     nmin_reg, nmin_next, nmax_reg, nmax_next, pend_reg, pend_next;
    logic [VB-1:0]     amin_reg, amin_next, amax_reg, amax_next;
    res_t              res_reg, res_next;

    logic [NODE_W-1:0] stk_idx [STACK_DEPTH];
    logic [POS_W-1:0]  stk_l   [STACK_DEPTH];
    logic [POS_W-1:0]  stk_r   [STACK_DEPTH];
    logic [1:0]        stk_ph  [STACK_DEPTH];

    logic [POS_W:0]    sum;
    logic [POS_W-1:0]  mid;
    logic [NODE_W-1:0] left_idx, right_idx;
    logic [SP_W-1:0]   sp_dec;
    logic              do_call, call_right, do_ret;
    logic [1:0]        saved_ph;
    logic [VB-1:0]     rd_min, rd_max, rd_pend;

    function automatic logic [WORD_W-1:0] add_word(input logic [WORD_W-1:0] w,
                                                    input logic [VB-1:0] d);
        logic [VB-1:0] p, mx, mn;
        p  = w[3*VB-1:2*VB] + d;
        mx = w[2*VB-1:VB] + d;
        mn = w[VB-1:0] + d;
        return {p, mx, mn};
    endfunction

    assign sum       = {1'b0, l_reg} + {1'b0, r_reg};
    assign mid       = sum[POS_W:1];
    assign left_idx  = {idx_reg[NODE_W-2:0], 1'b0};
    assign right_idx = {idx_reg[NODE_W-2:0], 1'b1};
    assign sp_dec    = sp_reg - 1'b1;
    assign rd_min    = mem_rd_data[VB-1:0];
    assign rd_max    = mem_rd_data[2*VB-1:VB];
    assign rd_pend   = mem_rd_data[3*VB-1:2*VB];

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        l_next      = l_reg;
        r_next      = r_reg;
        ph_next     = ph_reg;
        sp_next     = sp_reg;
        nmin_next   = nmin_reg;
        nmax_next   = nmax_reg;
        pend_next   = pend_reg;
        amin_next   = amin_reg;
        amax_next   = amax_reg;
        res_next    = res_reg;
        do_call     = 1'b0;
        call_right  = 1'b0;
        do_ret      = 1'b0;
        saved_ph    = ph_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = idx_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = idx_reg;
        mem_wr_data = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = op;
                    lo_next  = lo;
                    hi_next  = hi;
                    val_next = value;
                    idx_next = NODE_W'(1);
                    l_next   = POS_W'(1);
                    r_next   = span;
                    ph_next  = 2'd0;
                    sp_next  = '0;
                    res_next = '{found: 1'b0, position: '0, status: ST_OK};
                    case (op)
                        OP_LOAD:
                        begin
                            if (lo == '0 || lo > span)
                            begin
                                res_next.status = ST_BAD;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_LOAD;
                            end
                        end
                        OP_BUILD:
                        begin
                            state_next = S_VISIT;
                        end
                        OP_ADD:
                        begin
                            if (lo > hi)
                            begin
                                state_next = S_DONE;
                            end
                            else if (lo == '0 || hi > span)
                            begin
                                res_next.status = ST_BAD;
                                state_next      = S_DONE;
                            end
                            else
                            begin
                                state_next = S_VISIT;
                            end
                        end
                        OP_FIND:
                        begin
                            if (lo == '0)
                            begin
                                res_next.status = ST_BAD;
                                state_next      = S_DONE;
                            end
                            else if (lo > span)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_VISIT;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_LOAD:
            begin
                if (l_reg == r_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = {VB'(0), val_reg, val_reg};
                    state_next  = S_DONE;
                end
                else if (lo_reg <= mid)
                begin
                    idx_next = left_idx;
                    r_next   = mid;
                end
                else
                begin
                    idx_next = right_idx;
                    l_next   = POS_W'(mid + 1'b1);
                end
            end

            S_VISIT:
            begin
                case (op_reg)
                    OP_BUILD:
                    begin
                        case (ph_reg)
                            2'd0:
                            begin
                                if (l_reg == r_reg)
                                begin
                                    do_ret = 1'b1;
                                end
                                else
                                begin
                                    do_call  = 1'b1;
                                    saved_ph = 2'd1;
                                end
                            end
                            2'd1:
                            begin
                                do_call    = 1'b1;
                                call_right = 1'b1;
                                saved_ph   = 2'd2;
                            end
                            default:
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = left_idx;
                                state_next  = S_PULL_A;
                            end
                        endcase
                    end
                    OP_ADD:
                    begin
                        case (ph_reg)
                            2'd0:
                            begin
                                mem_rd_en = 1'b1;
                                if (lo_reg <= l_reg && r_reg <= hi_reg)
                                begin
                                    state_next = S_COVER;
                                end
                                else
                                begin
                                    state_next = S_CHK;
                                end
                            end
                            2'd1:
                            begin
                                if (lo_reg <= mid)
                                begin
                                    do_call  = 1'b1;
                                    saved_ph = 2'd2;
                                end
                                else
                                begin
                                    ph_next = 2'd2;
                                end
                            end
                            2'd2:
                            begin
                                if (hi_reg > mid)
                                begin
                                    do_call    = 1'b1;
                                    call_right = 1'b1;
                                    saved_ph   = 2'd3;
                                end
                                else
                                begin
                                    ph_next = 2'd3;
                                end
                            end
                            default:
                            begin
                                mem_rd_en   = 1'b1;
                                mem_rd_addr = left_idx;
                                state_next  = S_PULL_A;
                            end
                        endcase
                    end
                    OP_FIND:
                    begin
                        case (ph_reg)
                            2'd0:
                            begin
                                mem_rd_en  = 1'b1;
                                state_next = S_CHK;
                            end
                            2'd1:
                            begin
                                do_call    = 1'b1;
                                call_right = 1'b1;
                                saved_ph   = 2'd2;
                            end
                            2'd2:
                            begin
                                if (lo_reg <= mid)
                                begin
                                    do_call  = 1'b1;
                                    saved_ph = 2'd3;
                                end
                                else
                                begin
                                    do_ret = 1'b1;
                                end
                            end
                            default:
                            begin
                                do_ret = 1'b1;
                            end
                        endcase
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_CHK:
            begin
                nmin_next = rd_min;
                nmax_next = rd_max;
                pend_next = rd_pend;
                if (op_reg == OP_FIND &&
                    ($signed(val_reg) < $signed(rd_min) || $signed(rd_max) < $signed(val_reg)))
                begin
                    do_ret = 1'b1;
                end
                else if (op_reg == OP_FIND && l_reg == r_reg)
                begin
                    // Hit: drop the rest of the walk.
                    res_next.found    = 1'b1;
                    res_next.position = l_reg;
                    sp_next           = '0;
                    state_next        = S_DONE;
                end
                else if (rd_pend != '0)
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = left_idx;
                    state_next  = S_PUSH_A;
                end
                else
                begin
                    ph_next    = 2'd1;
                    state_next = S_VISIT;
                end
            end

            S_PUSH_A:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = left_idx;
                mem_wr_data = add_word(mem_rd_data, pend_reg);
                mem_rd_en   = 1'b1;
                mem_rd_addr = right_idx;
                state_next  = S_PUSH_B;
            end

            S_PUSH_B:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = right_idx;
                mem_wr_data = add_word(mem_rd_data, pend_reg);
                state_next  = S_PUSH_N;
            end

            S_PUSH_N:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = {VB'(0), nmax_reg, nmin_reg};
                ph_next     = 2'd1;
                state_next  = S_VISIT;
            end

            S_COVER:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data = add_word(mem_rd_data, val_reg);
                do_ret      = 1'b1;
            end

            S_PULL_A:
            begin
                amin_next   = rd_min;
                amax_next   = rd_max;
                mem_rd_en   = 1'b1;
                mem_rd_addr = right_idx;
                state_next  = S_PULL_B;
            end

            S_PULL_B:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_data[3*VB-1:2*VB] = '0;
                mem_wr_data[2*VB-1:VB]   = ($signed(amax_reg) < $signed(rd_max)) ?
                                           rd_max : amax_reg;
                mem_wr_data[VB-1:0]      = ($signed(rd_min) < $signed(amin_reg)) ?
                                           rd_min : amin_reg;
                do_ret      = 1'b1;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (do_call)
        begin
            sp_next    = sp_reg + 1'b1;
            ph_next    = 2'd0;
            state_next = S_VISIT;
            if (call_right)
            begin
                idx_next = right_idx;
                l_next   = POS_W'(mid + 1'b1);
            end
            else
            begin
                idx_next = left_idx;
                r_next   = mid;
            end
        end

        if (do_ret)
        begin
            if (sp_reg == '0)
            begin
                state_next = S_DONE;
            end
            else
            begin
                sp_next    = sp_dec;
                idx_next   = stk_idx[sp_dec[STK_AW-1:0]];
                l_next     = stk_l[sp_dec[STK_AW-1:0]];
                r_next     = stk_r[sp_dec[STK_AW-1:0]];
                ph_next    = stk_ph[sp_dec[STK_AW-1:0]];
                state_next = S_VISIT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sp_reg    <= '0;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            res_reg   <= res_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        lo_reg   <= lo_next;
        hi_reg   <= hi_next;
        val_reg  <= val_next;
        idx_reg  <= idx_next;
        l_reg    <= l_next;
        r_reg    <= r_next;
        ph_reg   <= ph_next;
        nmin_reg <= nmin_next;
        nmax_reg <= nmax_next;
        pend_reg <= pend_next;
        amin_reg <= amin_next;
        amax_reg <= amax_next;
        if (do_call)
        begin
            stk_idx[sp_reg[STK_AW-1:0]] <= idx_reg;
            stk_l[sp_reg[STK_AW-1:0]]   <= l_reg;
            stk_r[sp_reg[STK_AW-1:0]]   <= r_reg;
            stk_ph[sp_reg[STK_AW-1:0]]  <= saved_ph;
        end
    end

    assign idle      = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("walk stack overflow");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_rd_en && mem_wr_en && mem_rd_addr == mem_wr_addr))
        else $error("read and write of one node in the same cycle");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (sp_reg == '0))
        else $error("walk stack not empty when idle");

    a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_VISIT) |-> (l_reg != '0 && l_reg <= r_reg))
        else $error("node span out of order");

    a_found_find: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_reg.found) |-> (op_reg == OP_FIND && res_reg.position != '0))
        else $error("hit reported outside a find");

endmodule

>>> src/lazy_min_max_segment_tree.sv
// Channel | Direction | Handshake            | Payload
// cfg     | in        | cfg_valid/cfg_ready  | cfg_data (length_in_use)
// in      | in        | in_valid/in_ready    | op, index_low, index_high, operand
// out     | out       | out_valid/out_ready  | found, position, status
//
// One item at a time. Load walks from the root down to one leaf; build visits every node;
// range add updates covered nodes and pushes pending adds down at split nodes; find visits
// the nodes whose min and max may bracket the operand.
// After reset a clearing pass over all 4 * min(LEAVES, 2047) node entries holds in_ready low.
// A result waits in the output register while out_ready is low; the next item
// is taken meanwhile, and its result holds in the walker until the register frees.
module lazy_min_max_segment_tree import lmm_pkg::*; #(
    parameter int LEAVES     = LEAVES_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [POS_W-1:0]            cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  op,
    input  logic [POS_W-1:0]            index_low,
    input  logic [POS_W-1:0]            index_high,
    input  logic signed [OPERAND_W-1:0] operand,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        found,
    output logic [POS_W-1:0]            position,
    output logic                        status
);

    localparam int SPAN_MAX = (LEAVES < LEN_MAX) ? LEAVES : LEN_MAX;
    localparam int DEPTH    = 4 * SPAN_MAX;
    localparam int NODE_W   = $clog2(DEPTH);
    localparam int WORD_W   = 3 * VALUE_BITS;
    localparam logic [POS_W-1:0] SPAN_CAP = POS_W'(SPAN_MAX);

    logic [POS_W-1:0]      length_in_use_reg;
    logic [POS_W-1:0]      span;
    logic                  out_valid_reg;
    res_t                  out_reg;
    logic                  clearing, walker_idle, start;
    logic                  res_valid, res_ready;
    res_t                  res;
    logic [VALUE_BITS-1:0] value;
    logic                  mem_rd_en, mem_wr_en;
    logic [NODE_W-1:0]     mem_rd_addr, mem_wr_addr;
    logic [WORD_W-1:0]     mem_rd_data, mem_wr_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_in_use_reg <= LEN_RESET;
        end
        else if (cfg_valid)
        begin
            length_in_use_reg <= cfg_data;
        end
    end

    // Zero length acts as one; clamp to the tree size.
    always_comb
    begin
        if (length_in_use_reg == '0)
        begin
            span = POS_W'(1);
        end
        else if (length_in_use_reg > SPAN_CAP)
        begin
            span = SPAN_CAP;
        end
        else
        begin
            span = length_in_use_reg;
        end
    end

    // Sign-extend or wrap the operand to the element width.
    assign value    = VALUE_BITS'(operand);
    assign in_ready = walker_idle && !clearing;
    assign start    = in_valid && in_ready;

    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
            out_reg       <= res;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = out_reg.found;
    assign position  = out_reg.position;
    assign status    = out_reg.status;

    lmm_walker #(
        .LEAVES     (LEAVES),
        .VALUE_BITS (VALUE_BITS)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .op          (op_t'(op)),
        .lo          (index_low),
        .hi          (index_high),
        .value       (value),
        .span        (span),
        .idle        (walker_idle),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data)
    );

    lmm_node_mem #(
        .DEPTH  (DEPTH),
        .DATA_W (WORD_W)
    ) u_node_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (mem_rd_en),
        .rd_addr  (mem_rd_addr),
        .rd_data  (mem_rd_data),
        .wr_en    (mem_wr_en),
        .wr_addr  (mem_wr_addr),
        .wr_data  (mem_wr_data),
        .clearing (clearing)
    );

endmodule
